>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the pixel store block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define PPSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define PPSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ppsa_pkg.sv
// Package for the packed pixel store access block: field and address widths, register
// indexes, request commands and the memory control type. Depends on nothing.

package ppsa_pkg;

    // Field widths of the request and result items.
    localparam int COL_W  = 12;
    localparam int ROW_W  = 12;
    localparam int PIX_W  = 24;
    localparam int BPP_W  = 5;
    localparam int DIM_W  = 13;

    // Largest pixel depth; deeper settings saturate to it.
    localparam logic [BPP_W-1:0] MAX_DEPTH = 5'd24;

    // Address arithmetic widths: pixel index, bit address, bound sum.
    localparam int PIX_IDX_W  = 26;
    localparam int BIT_ADDR_W = 31;
    localparam int SUM_W      = 32;
    localparam int BIT_OFF_W  = 3;
    localparam int BYTE_OFF_W = BIT_ADDR_W - BIT_OFF_W;

    // The store is split into byte lanes so a 32-bit window is read from all lanes at once.
    localparam int LANES  = 4;
    localparam int LANE_W = 2;
    localparam int WIN_W  = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

    // Request commands.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Control of the lane memories: read enable and per-lane write enables.
    typedef struct packed {
        logic             rd_en;
        logic [LANES-1:0] wr_en;
    } t_mem_ctl;

endpackage

>>> hw/rtl/ppsa_banks.sv
// Byte-lane pixel memory: four interleaved banks, one registered read and
// one write per bank each cycle. Depends on ppsa_pkg.

module ppsa_banks #(
    parameter int STORE_BYTES = 65536
) (
    input  logic                                          i_clk,
    input  ppsa_pkg::t_mem_ctl                            i_ctl,
    input  logic [ppsa_pkg::LANES*BankAddrW(STORE_BYTES)-1:0] i_rd_addr,
    input  logic [ppsa_pkg::LANES*BankAddrW(STORE_BYTES)-1:0] i_wr_addr,
    input  logic [ppsa_pkg::WIN_W-1:0]                    i_wr_data,
    output logic [ppsa_pkg::WIN_W-1:0]                    o_rd_data
);

    // Address width of one bank, at least one bit.
    function automatic int BankAddrW(input int Bytes);
        int words;
        begin
            words = (Bytes + 3) / 4;
            return (words > 1) ? $clog2(words) : 1;
        end
    endfunction

    localparam int BANK_WORDS = (STORE_BYTES + ppsa_pkg::LANES - 1) / ppsa_pkg::LANES;
    localparam int AW         = BankAddrW(STORE_BYTES);

    // Each lane holds every fourth byte of the store.
    for (genvar g = 0; g < ppsa_pkg::LANES; g++) begin : g_lane
        logic [7:0] r_mem [BANK_WORDS];
        logic [7:0] r_rd_byte;

        always_ff @(posedge i_clk) begin
            if (i_ctl.wr_en[g]) begin
                r_mem[i_wr_addr[g*AW +: AW]] <= i_wr_data[g*8 +: 8];
            end
            if (i_ctl.rd_en) begin
                r_rd_byte <= r_mem[i_rd_addr[g*AW +: AW]];
            end
        end

        assign o_rd_data[g*8 +: 8] = r_rd_byte;
    end

endmodule

>>> hw/rtl/packed_pixel_store_access_core.sv
// Top level of the packed pixel store access block: request decode, address
// arithmetic, read-modify-write control and result register.
// Depends on ppsa_pkg and ppsa_banks.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata: col,row,write_value; tuser: cmd
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: read_value; tuser: out_of_range
//  cfg       in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// A request passes through an address cycle that multiplies by the depth and
// issues the lane memory read, and a modify cycle that writes back and loads the
// result. A new request can be taken in the modify cycle of the last one, not before,
// since each request makes a single read-then-write pass over the lane memories.
// Reset (synchronous, active low) returns control to idle and loads the register
// defaults; the store itself is not cleared. A stalled result holds the modify
// cycle, and no new request is taken until the result register can load.

module packed_pixel_store_access_core #(
    parameter int STORE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [11:0] col, [23:12] row, [47:24] write_value
    input  logic [0:0]  i_s_axis_tuser,   // [0] cmd
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] read_value
    output logic [0:0]  o_m_axis_tuser,   // [0] out_of_range
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ppsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppsa_pkg::DIM_W-1:0]     i_cfg_data
);

    function automatic int BankAddrW(input int Bytes);
        int words;
        begin
            words = (Bytes + 3) / 4;
            return (words > 1) ? $clog2(words) : 1;
        end
    endfunction

    localparam int AW = BankAddrW(STORE_BYTES);
    localparam logic [ppsa_pkg::SUM_W-1:0] STORE_BITS = ppsa_pkg::SUM_W'(STORE_BYTES * 8);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADDR = 3'b010,
        S_MOD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [ppsa_pkg::BPP_W-1:0] r_bpp;
    logic [ppsa_pkg::DIM_W-1:0] r_width;
    logic [ppsa_pkg::DIM_W-1:0] r_height;

    // Request fields.
    logic                           in_cmd;
    logic [ppsa_pkg::COL_W-1:0]     in_col;
    logic [ppsa_pkg::ROW_W-1:0]     in_row;
    logic [ppsa_pkg::PIX_W-1:0]     in_wval;

    // Registers of the request in flight.
    logic                           r_cmd;
    logic [ppsa_pkg::PIX_W-1:0]     r_wval;
    logic [ppsa_pkg::PIX_IDX_W-1:0] r_pix_idx;
    logic                           r_coord_oor;
    logic                           r_oor;
    logic [ppsa_pkg::BIT_OFF_W-1:0] r_bit_off;
    logic [ppsa_pkg::LANE_W-1:0]    r_rot;
    logic [ppsa_pkg::PIX_W-1:0]     r_mask;
    logic [ppsa_pkg::LANES*AW-1:0]  r_wr_addr;

    // Result register.
    logic                           r_out_valid;
    logic [ppsa_pkg::PIX_W-1:0]     r_out_value;
    logic                           r_out_oor;

    // Address cycle signals.
    logic [ppsa_pkg::BPP_W-1:0]      depth;
    logic [ppsa_pkg::BIT_ADDR_W-1:0] bit_addr;
    logic [ppsa_pkg::BYTE_OFF_W-1:0] byte_off;
    logic [ppsa_pkg::SUM_W-1:0]      bit_end;
    logic                            addr_oor;
    logic [ppsa_pkg::PIX_W:0]        depth_mask;
    logic [ppsa_pkg::LANES*AW-1:0]   lane_addr;

    // Modify cycle signals.
    logic [ppsa_pkg::WIN_W-1:0] rd_data;
    logic [ppsa_pkg::WIN_W-1:0] window;
    logic [ppsa_pkg::WIN_W-1:0] field_mask;
    logic [ppsa_pkg::WIN_W-1:0] new_window;
    logic [ppsa_pkg::WIN_W-1:0] wr_data;
    logic [ppsa_pkg::LANES-1:0] byte_touched;
    logic [ppsa_pkg::LANES-1:0] lane_touched;
    logic [ppsa_pkg::PIX_W-1:0] rd_value;
    logic                       do_write;

    logic               in_accept;
    logic               out_load;
    ppsa_pkg::t_mem_ctl mem_ctl;

    assign in_cmd  = i_s_axis_tuser[0];
    assign in_col  = i_s_axis_tdata[11:0];
    assign in_row  = i_s_axis_tdata[23:12];
    assign in_wval = i_s_axis_tdata[47:24];

    // Handshakes: the result register loads in the modify cycle, which also
    // frees the block for the next request.
    assign out_load        = (r_state == S_MOD) && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = (r_state == S_IDLE) || out_load;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (out_load) n_state = in_accept ? S_ADDR : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= 5'd8;
            r_width  <= 13'd256;
            r_height <= 13'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ppsa_pkg::CFG_BITS_PER_PIXEL: r_bpp    <= i_cfg_data[ppsa_pkg::BPP_W-1:0];
                ppsa_pkg::CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data;
                ppsa_pkg::CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture: pixel index and coordinate bounds.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd       <= in_cmd;
            r_wval      <= in_wval;
            r_pix_idx   <= ppsa_pkg::PIX_IDX_W'(in_col)
                         + ppsa_pkg::PIX_IDX_W'(in_row) * ppsa_pkg::PIX_IDX_W'(r_width);
            r_coord_oor <= ({1'b0, in_col} >= r_width) || ({1'b0, in_row} >= r_height);
        end
    end

    // Address cycle: bit address, store bound and per-lane byte addresses.
    assign depth      = (r_bpp > ppsa_pkg::MAX_DEPTH) ? ppsa_pkg::MAX_DEPTH : r_bpp;
    assign bit_addr   = ppsa_pkg::BIT_ADDR_W'(r_pix_idx) * ppsa_pkg::BIT_ADDR_W'(depth);
    assign byte_off   = bit_addr[ppsa_pkg::BIT_ADDR_W-1:ppsa_pkg::BIT_OFF_W];
    assign bit_end    = ppsa_pkg::SUM_W'(bit_addr) + ppsa_pkg::SUM_W'(depth);
    assign addr_oor   = r_coord_oor || (bit_end > STORE_BITS);
    assign depth_mask = (25'd1 << depth) - 25'd1;

    // Lane k holds window byte (k - rot) mod 4; lanes below rot step to the next word.
    for (genvar g = 0; g < ppsa_pkg::LANES; g++) begin : g_addr
        logic [ppsa_pkg::LANE_W-1:0]     lane_ofs;
        logic [ppsa_pkg::BYTE_OFF_W-1:0] lane_byte;
        assign lane_ofs  = ppsa_pkg::LANE_W'(g) - byte_off[ppsa_pkg::LANE_W-1:0];
        assign lane_byte = byte_off + ppsa_pkg::BYTE_OFF_W'(lane_ofs);
        assign lane_addr[g*AW +: AW] = lane_byte[AW+ppsa_pkg::LANE_W-1:ppsa_pkg::LANE_W];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_oor     <= addr_oor;
            r_bit_off <= bit_addr[ppsa_pkg::BIT_OFF_W-1:0];
            r_rot     <= byte_off[ppsa_pkg::LANE_W-1:0];
            r_mask    <= depth_mask[ppsa_pkg::PIX_W-1:0];
            r_wr_addr <= lane_addr;
        end
    end

    // Modify cycle: gather the window, extract or merge the pixel field.
    for (genvar g = 0; g < ppsa_pkg::LANES; g++) begin : g_win
        logic [ppsa_pkg::LANE_W-1:0] src_lane;
        logic [ppsa_pkg::LANE_W-1:0] win_byte;
        assign src_lane = r_rot + ppsa_pkg::LANE_W'(g);
        assign win_byte = ppsa_pkg::LANE_W'(g) - r_rot;
        assign window[g*8 +: 8]  = rd_data[8*src_lane +: 8];
        assign wr_data[g*8 +: 8] = new_window[8*win_byte +: 8];
        assign byte_touched[g]   = |field_mask[g*8 +: 8];
        assign lane_touched[g]   = byte_touched[win_byte];
    end

    assign field_mask = ppsa_pkg::WIN_W'(r_mask) << r_bit_off;
    assign new_window = (window & ~field_mask)
                      | (ppsa_pkg::WIN_W'(r_wval & r_mask) << r_bit_off);
    assign rd_value   = ppsa_pkg::PIX_W'(window >> r_bit_off) & r_mask;
    assign do_write   = out_load && !r_oor && (r_cmd == ppsa_pkg::CMD_WRITE);

    assign mem_ctl.rd_en = (r_state == S_ADDR);
    assign mem_ctl.wr_en = do_write ? lane_touched : '0;

    ppsa_banks #(
        .STORE_BYTES (STORE_BYTES)
    ) u_banks (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (lane_addr),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= (r_oor || (r_cmd == ppsa_pkg::CMD_WRITE)) ? '0 : rd_value;
            r_out_oor   <= r_oor;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_value;
    assign o_m_axis_tuser[0] = r_out_oor;

endmodule

>>> hw/rtl/ppsa_checker.sv
// Port-level checker for the packed pixel store access block, attached to the
// top level by bind. Depends on assert_macros.svh.
`include "assert_macros.svh"

module ppsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [0:0]  i_m_tuser
);

    // A result that is not taken stays offered.
    `PPSA_ASSERT(a_out_hold, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> i_m_tvalid, "result dropped while stalled")

    // An out-of-range result never carries pixel data.
    `PPSA_ASSERT(a_oor_zero, i_clk, i_rst_n, (i_m_tvalid && i_m_tuser[0]) |-> (i_m_tdata == 24'd0), "out-of-range result with nonzero value")

    // The block is busy in the cycle after it takes a request.
    `PPSA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_s_tvalid && i_s_tready) |=> !i_s_tready, "request taken during address cycle")

    // Reset empties the result register.
    `PPSA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_m_tvalid, "result valid after reset")

endmodule

bind packed_pixel_store_access_core ppsa_checker u_ppsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);
